@@ src/dowu_pkg.sv @@
`default_nettype none

package dowu_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 4;
    localparam int YEAR_W    = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 4'd1;

    localparam logic [YEAR_W-1:0] RESET_MIN_YEAR = 12'd1900;
    localparam logic [YEAR_W-1:0] RESET_MAX_YEAR = 12'd2021;

    typedef struct packed {
        logic load;
        logic split;
        logic check;
        logic walk;
        logic zell;
        logic emit;
    } dowu_cmd_t;

    typedef struct packed {
        logic split_done;
        logic walk_fits;
        logic out_free;
    } dowu_sts_t;

endpackage

`default_nettype wire

@@ src/date_offset_weekday_unit.sv @@
// Channel   Direction  Handshake              Contents
// s_*       in         s_tvalid / s_tready    in_year, in_month, in_day, offset_days
// m_*       out        m_tvalid / m_tready    out_year, out_month, out_day, leap_year, weekday
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data (year limits)
//
// One item at a time: it is accepted, the year is split into century and year
// by repeated subtraction of 100, the date is checked, the offset is walked off
// month by month, the weekday is computed and the output register is loaded.
// A finished item waits in the output register; the next item is taken meanwhile.
// Reset clears the controller, the output valid and sets the year limits.
`default_nettype none

module date_offset_weekday_unit
    import dowu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // in_year, in_month, in_day, offset_days
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_year, out_month, out_day, leap_year, weekday
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [YEAR_W-1:0]    cfg_data
);

    dowu_cmd_t cmd;
    dowu_sts_t sts;

    assign cfg_ready = 1'b1;

    dowu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dowu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ src/dowu_ctrl.sv @@
`default_nettype none

module dowu_ctrl
    import dowu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dowu_sts_t sts,
    output dowu_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPLIT = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_ZELL  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (sts.split_done)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.split = 1'b1;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_fits)
                begin
                    state_next = ST_ZELL;
                end
            end
            ST_ZELL:
            begin
                cmd.zell   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/dowu_dp.sv @@
`default_nettype none

module dowu_dp
    import dowu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [YEAR_W-1:0]    cfg_data,
    input  dowu_cmd_t            cmd,
    output dowu_sts_t            sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic signed [7:0] FALLBACK_CENT = 8'sd19;
    localparam logic [6:0]        LAST_YIC      = 7'd99;
    localparam logic [3:0]        MONTH_JAN     = 4'd1;
    localparam logic [3:0]        MONTH_FEB     = 4'd2;
    localparam logic [3:0]        MONTH_DEC     = 4'd12;
    localparam logic [10:0]       ZSUM_BIAS     = 11'd140;

    function automatic logic is_leap(input logic [7:0] cent, input logic [6:0] yic);
        logic res;
        if (yic == 7'd0)
        begin
            res = (cent[1:0] == 2'b00);
        end
        else
        begin
            res = (yic[1:0] == 2'b00);
        end
        return res;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] res;
        case (m) inside
            MONTH_FEB:                  res = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    res = 5'd30;
            default:                    res = 5'd31;
        endcase
        return res;
    endfunction

    function automatic logic [5:0] zeller_month(input logic [3:0] mm);
        logic [5:0] res;
        case (mm)
            4'd3:    res = 6'd10;
            4'd4:    res = 6'd13;
            4'd5:    res = 6'd15;
            4'd6:    res = 6'd18;
            4'd7:    res = 6'd20;
            4'd8:    res = 6'd23;
            4'd9:    res = 6'd26;
            4'd10:   res = 6'd28;
            4'd11:   res = 6'd31;
            4'd12:   res = 6'd33;
            4'd13:   res = 6'd36;
            4'd14:   res = 6'd39;
            default: res = 6'd0;
        endcase
        return res;
    endfunction

    // fold by 64 and by 8, both congruent to 1 mod 7
    function automatic logic [2:0] mod7(input logic [8:0] v);
        logic [6:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = {4'd0, v[8:6]} + {1'b0, v[5:0]};
        s2 = s1[6:3] + {1'b0, s1[2:0]};
        if (s2 >= 4'd14)
        begin
            r = s2 - 4'd14;
        end
        else if (s2 >= 4'd7)
        begin
            r = s2 - 4'd7;
        end
        else
        begin
            r = s2;
        end
        return r[2:0];
    endfunction

    logic [YEAR_W-1:0] min_year_reg;
    logic [YEAR_W-1:0] max_year_reg;

    logic [YEAR_W-1:0] in_year_reg;
    logic [YEAR_W-1:0] yrem_reg;
    logic [7:0]        cent_reg;
    logic [6:0]        yic_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    logic              neg_reg;
    logic              fill_reg;
    logic [16:0]       rem_reg;
    logic [8:0]        zsum_reg;
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [YEAR_W-1:0] in_year;
    logic [3:0]        in_month;
    logic [4:0]        in_day;
    logic [16:0]       offset_days;
    logic [16:0]       offset_mag;

    assign in_year     = s_tdata[11:0];
    assign in_month    = s_tdata[15:12];
    assign in_day      = s_tdata[20:16];
    assign offset_days = s_tdata[37:21];
    assign offset_mag  = offset_days[16] ? (~offset_days + 17'd1) : offset_days;

    // validation of the input date
    logic split_leap;
    logic date_ok;

    assign split_leap = is_leap(cent_reg, yrem_reg[6:0]);
    assign date_ok    = (in_year_reg >= min_year_reg) && (in_year_reg <= max_year_reg)
                     && (month_reg != 4'd0) && (month_reg <= MONTH_DEC)
                     && (day_reg != 5'd0)
                     && (day_reg <= month_days(month_reg, split_leap));

    // month walk
    logic       cur_leap;
    logic [4:0] dim;
    logic [4:0] eff_day;
    logic [4:0] room;
    logic [5:0] step_len;
    logic       fits;
    logic [7:0] cent_inc;
    logic [6:0] yic_inc;
    logic [7:0] cent_dec;
    logic [6:0] yic_dec;

    assign cur_leap = is_leap(cent_reg, yic_reg);
    assign dim      = month_days(month_reg, cur_leap);
    assign eff_day  = (neg_reg && fill_reg) ? dim : day_reg;
    assign room     = neg_reg ? (eff_day - 5'd1) : (dim - eff_day);
    assign step_len = neg_reg ? {1'b0, eff_day} : ({1'b0, room} + 6'd1);
    assign fits     = (rem_reg <= {12'd0, room});

    assign cent_inc = (yic_reg == LAST_YIC) ? (cent_reg + 8'd1) : cent_reg;
    assign yic_inc  = (yic_reg == LAST_YIC) ? 7'd0 : (yic_reg + 7'd1);
    assign cent_dec = (yic_reg == 7'd0) ? (cent_reg - 8'd1) : cent_reg;
    assign yic_dec  = (yic_reg == 7'd0) ? LAST_YIC : (yic_reg - 7'd1);

    // weekday sum, biased positive
    logic        early;
    logic [6:0]  zk;
    logic [7:0]  zc;
    logic [3:0]  zm;
    logic [10:0] zsum;

    assign early = (month_reg <= MONTH_FEB);
    assign zk    = early ? yic_dec : yic_reg;
    assign zc    = early ? cent_dec : cent_reg;
    assign zm    = early ? (month_reg + 4'd12) : month_reg;
    assign zsum  = {4'd0, zk} + {6'd0, zk[6:2]} + {{5{zc[7]}}, zc[7:2]}
                 - {{2{zc[7]}}, zc, 1'b0} + {5'd0, zeller_month(zm)}
                 + {6'd0, day_reg} + ZSUM_BIAS - 11'd1;

    logic [YEAR_W-1:0] year_out;

    assign year_out = {cent_reg[5:0], 6'd0} + {cent_reg[6:0], 5'd0}
                    + {{2{cent_reg[7]}}, cent_reg, 2'd0} + {5'd0, yic_reg};

    assign sts.split_done = (yrem_reg < 12'd100);
    assign sts.walk_fits  = fits;
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= RESET_MIN_YEAR;
            max_year_reg <= RESET_MAX_YEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_YEAR: min_year_reg <= cfg_data;
                CFG_MAX_YEAR: max_year_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_year_reg <= in_year;
            yrem_reg    <= in_year;
            cent_reg    <= 8'd0;
            month_reg   <= in_month;
            day_reg     <= in_day;
            neg_reg     <= offset_days[16];
            rem_reg     <= offset_mag;
            fill_reg    <= 1'b0;
        end
        if (cmd.split)
        begin
            yrem_reg <= yrem_reg - 12'd100;
            cent_reg <= cent_reg + 8'd1;
        end
        if (cmd.check)
        begin
            if (date_ok)
            begin
                yic_reg <= yrem_reg[6:0];
            end
            else
            begin
                cent_reg  <= FALLBACK_CENT;
                yic_reg   <= 7'd0;
                month_reg <= MONTH_JAN;
                day_reg   <= 5'd1;
            end
        end
        if (cmd.walk)
        begin
            if (fits)
            begin
                day_reg  <= neg_reg ? (eff_day - rem_reg[4:0]) : (day_reg + rem_reg[4:0]);
                fill_reg <= 1'b0;
            end
            else
            begin
                rem_reg <= rem_reg - {11'd0, step_len};
                if (neg_reg)
                begin
                    fill_reg <= 1'b1;
                    if (month_reg == MONTH_JAN)
                    begin
                        month_reg <= MONTH_DEC;
                        cent_reg  <= cent_dec;
                        yic_reg   <= yic_dec;
                    end
                    else
                    begin
                        month_reg <= month_reg - 4'd1;
                    end
                end
                else
                begin
                    day_reg <= 5'd1;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_reg <= MONTH_JAN;
                        cent_reg  <= cent_inc;
                        yic_reg   <= yic_inc;
                    end
                    else
                    begin
                        month_reg <= month_reg + 4'd1;
                    end
                end
            end
        end
        if (cmd.zell)
        begin
            zsum_reg <= zsum[8:0];
        end
        if (cmd.emit)
        begin
            out_data_reg <= {7'd0, mod7(zsum_reg), cur_leap, day_reg, month_reg, year_out};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ src/dowu_checker.sv @@
`default_nettype none

module dowu_checker
    import dowu_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12))
        else $error("month out of range");

    a_day_wday: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:16] != 5'd0) && (m_tdata[24:22] != 3'd7))
        else $error("day or weekday out of range");

endmodule

bind date_offset_weekday_unit dowu_checker u_checker (.*);

`default_nettype wire

@@ dv/tb_date_offset_weekday_unit.sv @@
`timescale 1ns / 1ps

module tb_date_offset_weekday_unit;
    import dowu_pkg::*;

    localparam int                   STALL_LIMIT = 20000;
    localparam int                   DIR_N       = 24;
    localparam int                   MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 4'd9;

    typedef enum logic [2:0] {
        SUNDAY, MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY, SATURDAY
    } weekday_t;

    typedef struct packed {
        logic [16:0] offset;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } date_req_t;

    typedef struct packed {
        logic [2:0]  wday;
        logic        leap;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } cal_date_t;

    typedef struct packed {
        logic      known;
        cal_date_t want;
        date_req_t req;
    } date_row_t;

    function automatic date_row_t row_auto(int y, int m, int d, int off);
        date_row_t r;
        r.known     = 1'b0;
        r.want      = '0;
        r.req.year  = 12'(y);
        r.req.month = 4'(m);
        r.req.day   = 5'(d);
        r.req.offset = 17'(off);
        return r;
    endfunction

    function automatic date_row_t row_known(int y, int m, int d, int off,
                                            int ey, int em, int ed, bit el, weekday_t ew);
        date_row_t r;
        r            = row_auto(y, m, d, off);
        r.known      = 1'b1;
        r.want.year  = 12'(ey);
        r.want.month = 4'(em);
        r.want.day   = 5'(ed);
        r.want.leap  = el;
        r.want.wday  = ew;
        return r;
    endfunction

    localparam date_row_t DIR_TAB [DIR_N] = '{
        row_known(1900,  1,  1,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2021, 12, 31,      0, 2021, 12, 31, 1'b0, FRIDAY),
        row_known(2000,  2, 29,      0, 2000,  2, 29, 1'b1, TUESDAY),
        row_known(1900,  2, 29,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(1899,  6, 15,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2022,  1,  1,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2000,  0, 10,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2000, 13, 10,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2000, 15, 31,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2000,  4, 31,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(2000,  1,  0,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(   0,  0,  0,      0, 1900,  1,  1, 1'b0, MONDAY),
        row_known(1900,  1,  1,      1, 1900,  1,  2, 1'b0, TUESDAY),
        row_known(1900,  1,  1,     -1, 1899, 12, 31, 1'b0, SUNDAY),
        row_known(1999, 12, 31,      1, 2000,  1,  1, 1'b1, SATURDAY),
        row_known(2000,  2, 28,      1, 2000,  2, 29, 1'b1, TUESDAY),
        row_known(2019,  2, 28,      1, 2019,  3,  1, 1'b0, FRIDAY),
        row_known(2020,  3,  1,     -1, 2020,  2, 29, 1'b1, SATURDAY),
        row_auto (2000,  1,  1,  65535),
        row_auto (2000,  1,  1, -65536),
        row_auto (2021, 12, 31,  65535),
        row_auto (1900,  1,  1, -65536),
        row_auto (2021, 12, 31, -65535),
        row_auto (4095, 15, 31, -65536)
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [YEAR_W-1:0]    cfg_data  = '0;

    logic [YEAR_W-1:0] lim_min = RESET_MIN_YEAR;
    logic [YEAR_W-1:0] lim_max = RESET_MAX_YEAR;

    date_row_t date_q [$];
    cal_date_t due_dates [$];

    int snd_idle   = 0;
    int rcv_idle   = 0;
    int errors     = 0;
    int dates_in   = 0;
    int dates_out  = 0;
    int cfg_writes = 0;
    int stall      = 0;

    date_offset_weekday_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int fdiv(int a, int b);
        int q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int fmod(int a, int b);
        return a - fdiv(a, b) * b;
    endfunction

    function automatic bit leap_of(int y);
        return (fmod(y, 4) == 0 && fmod(y, 100) != 0) || fmod(y, 400) == 0;
    endfunction

    function automatic int month_days(int y, int m);
        case (m)
            2:           return leap_of(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic logic [2:0] zeller(int y, int m, int d);
        int c;
        int k;
        int w;
        if (m <= 2)
        begin
            y = y - 1;
            m = m + 12;
        end
        c = fdiv(y, 100);
        k = y - 100 * c;
        w = k + fdiv(k, 4) + fdiv(c, 4) - 2 * c + (26 * (m + 1)) / 10 + d - 1;
        return 3'(fmod(w, 7));
    endfunction

    function automatic cal_date_t shift_date(date_req_t r);
        int        y;
        int        m;
        int        d;
        int        off;
        int        rem;
        int        room;
        cal_date_t res;
        off = int'($signed(r.offset));
        if (r.year < lim_min || r.year > lim_max || r.month < 1 || r.month > 12 ||
            r.day < 1 || int'(r.day) > month_days(int'(r.year), int'(r.month)))
        begin
            y = 1900;
            m = 1;
            d = 1;
        end
        else
        begin
            y = int'(r.year);
            m = int'(r.month);
            d = int'(r.day);
        end
        rem = (off < 0) ? -off : off;
        while (rem > 0)
        begin
            if (off > 0)
            begin
                room = month_days(y, m) - d;
                if (rem <= room)
                begin
                    d   = d + rem;
                    rem = 0;
                end
                else
                begin
                    rem = rem - room - 1;
                    d   = 1;
                    if (m == 12)
                    begin
                        m = 1;
                        y = y + 1;
                    end
                    else
                        m = m + 1;
                end
            end
            else
            begin
                room = d - 1;
                if (rem <= room)
                begin
                    d   = d - rem;
                    rem = 0;
                end
                else
                begin
                    rem = rem - room - 1;
                    if (m == 1)
                    begin
                        m = 12;
                        y = y - 1;
                    end
                    else
                        m = m - 1;
                    d = month_days(y, m);
                end
            end
        end
        res.year  = 12'(y);
        res.month = 4'(m);
        res.day   = 5'(d);
        res.leap  = leap_of(y);
        res.wday  = zeller(y, m, d);
        return res;
    endfunction

    function automatic date_row_t rand_date(int lo, int hi);
        int        y;
        int        m;
        int        d;
        int        off;
        int        r;
        bit        edge_year;
        date_row_t row;
        edge_year = 1'b0;
        if (lo <= hi && $urandom_range(99) < 75)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                y         = lo;
                edge_year = 1'b1;
            end
            else if (r < 16)
            begin
                y         = hi;
                edge_year = 1'b1;
            end
            else
                y = $urandom_range(hi, lo);
            m = $urandom_range(12, 1);
            d = $urandom_range(month_days(y, m), 1);
        end
        else
        begin
            y = $urandom_range(4095, 0);
            m = $urandom_range(15, 0);
            d = $urandom_range(31, 0);
        end
        r = $urandom_range(99);
        if (r < 60)
            off = $urandom_range(400);
        else if (r < 85)
            off = $urandom_range(6000);
        else if (r < 96)
            off = $urandom_range(65535);
        else
            off = 0;
        if ($urandom_range(1))
            off = -off;
        // from the edge years, use the largest offsets; at 0 or 4095 the walk leaves the 12-bit year range
        if (edge_year && $urandom_range(1))
            off = $urandom_range(1) ? 65535 : -65536;
        row = row_auto(y, m, d, off);
        return row;
    endfunction

    task automatic flag_error(string what);
        errors = errors + 1;
        if (errors <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                due_dates.push_back(date_q[0].known ? date_q[0].want
                                                    : shift_date(date_q[0].req));
                void'(date_q.pop_front());
                dates_in = dates_in + 1;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (date_q.size() != 0 && $urandom_range(99) >= snd_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(date_q[0].req);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : rx_side
        cal_date_t got;
        cal_date_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            lim_min  <= RESET_MIN_YEAR;
            lim_max  <= RESET_MAX_YEAR;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got       = cal_date_t'(m_tdata[$bits(cal_date_t)-1:0]);
                dates_out = dates_out + 1;
                if (due_dates.size() == 0)
                    flag_error($sformatf("unexpected date %0d-%0d-%0d",
                                         got.year, got.month, got.day));
                else
                begin
                    want = due_dates.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.leap !== want.leap ||
                        got.wday !== want.wday)
                        flag_error($sformatf(
                            "date mismatch: want %0d-%0d-%0d leap %0d wd %0d, got %0d-%0d-%0d leap %0d wd %0d",
                            want.year, want.month, want.day, want.leap, want.wday,
                            got.year, got.month, got.day, got.leap, got.wday));
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_idle);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_YEAR: lim_min <= cfg_data;
                    CFG_MAX_YEAR: lim_max <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall = 0;
        else
            stall = stall + 1;
        if (stall >= STALL_LIMIT)
        begin
            $display("stalled for %0d cycles, %0d dates still due", stall, due_dates.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        while (date_q.size() != 0 || s_tvalid || due_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [YEAR_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cfg_writes = cfg_writes + 1;
    endtask

    task automatic run_phase(int lo, int hi, int snd, int rcv, int count);
        wait_idle();
        write_reg(CFG_MIN_YEAR, 12'(lo));
        write_reg(CFG_MAX_YEAR, 12'(hi));
        snd_idle = snd;
        rcv_idle = rcv;
        for (int i = 0; i < count; i++)
            date_q.push_back(rand_date(lo, hi));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 36;
        rcv_idle = 61;
        for (int i = 0; i < DIR_N; i++)
            date_q.push_back(DIR_TAB[i]);

        run_phase(0, 4095, 36, 61, 90);
        // crossed limits: everything falls back
        run_phase(2500, 1000, 61, 36, 15);
        run_phase(1583, 2400, 61, 36, 90);
        run_phase(4095, 4095, 0, 0, 25);
        wait_idle();
        write_reg(CFG_SPARE, 12'h5A5);
        run_phase(0, 0, 0, 0, 25);

        wait_idle();
        repeat (60) @(posedge clk);
        if (due_dates.size() != 0)
            flag_error($sformatf("%0d dates never came out", due_dates.size()));

        $display("%0d dates in (%0d directed), %0d out, %0d limit writes, %0d mismatches",
                 dates_in, DIR_N, dates_out, cfg_writes, errors);
        $display("limits: reset, full, crossed, mid, single year at both ends");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
